// File: rtl/jtl_pkg.sv
package jtl_pkg;

  localparam int unsigned ValueWidthDefault = 64;

  // Token kinds carried on the result channel.
  typedef enum logic [3:0] {
    KIND_OBJ_OPEN  = 4'd0,
    KIND_OBJ_CLOSE = 4'd1,
    KIND_ARR_OPEN  = 4'd2,
    KIND_ARR_CLOSE = 4'd3,
    KIND_COMMA     = 4'd4,
    KIND_COLON     = 4'd5,
    KIND_STR_CHAR  = 4'd6,
    KIND_STR_END   = 4'd7,
    KIND_INTEGER   = 4'd8,
    KIND_REAL      = 4'd9,
    KIND_NULL      = 4'd10,
    KIND_BOOL      = 4'd11,
    KIND_INVALID   = 4'd12,
    KIND_END       = 4'd13,
    KIND_UNTERM    = 4'd14
  } kind_e;

  typedef enum logic [7:0] {
    MODE_IDLE   = 8'b0000_0001,
    MODE_STR    = 8'b0000_0010,
    MODE_ESC    = 8'b0000_0100,
    MODE_NUM    = 8'b0000_1000,
    MODE_WORD   = 8'b0001_0000,
    MODE_CMT    = 8'b0010_0000,
    MODE_SLASH  = 8'b0100_0000,
    MODE_BADCMT = 8'b1000_0000
  } mode_e;

  // Prefix state of a number token.
  localparam logic [1:0] HexNone   = 2'd0;
  localparam logic [1:0] HexZero   = 2'd1;
  localparam logic [1:0] HexActive = 2'd2;
  localparam logic [1:0] HexNoPfx  = 2'd3;

  localparam logic [7:0] CharEscape = 8'h1b;

  localparam logic [39:0] WordNull  = 40'h00_6E_75_6C_6C;
  localparam logic [39:0] WordTrue  = 40'h00_74_72_75_65;
  localparam logic [39:0] WordFalse = 40'h66_61_6C_73_65;

  localparam int unsigned QueueDepth = 3;

endpackage

// File: rtl/jtl_in_if.sv
interface jtl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_text;

  modport source (output valid, output char_in, output end_of_text, input ready);
  modport sink (input valid, input char_in, input end_of_text, output ready);
endinterface

// File: rtl/jtl_out_if.sv
interface jtl_out_if #(
  parameter int unsigned VALUE_WIDTH = jtl_pkg::ValueWidthDefault
);
  logic                   valid;
  logic                   ready;
  jtl_pkg::kind_e         kind;
  logic [VALUE_WIDTH-1:0] value;
  logic                   negative;
  logic                   last;

  modport source (output valid, output kind, output value, output negative, output last,
                  input ready);
  modport sink (input valid, input kind, input value, input negative, input last,
                output ready);
endinterface

// File: rtl/json_token_lexer_core.sv
// JSON lexer that takes one byte per item and returns tokens: structural
// characters, decoded string characters with an end marker, integers of
// VALUE_WIDTH bits (real numbers reported without a value), null, true and
// false. An item gives zero, one or two results; the second one appears when
// a number or word is closed by a structural character, or when end of text
// closes a number, a word or an unfinished slash comment. Each accepted item
// is decoded in the cycle it is accepted and its results enter a three-entry
// result queue whose head drives the output. An item is accepted whenever the
// queue holds at most one result, so items that each give at most one result
// run at one item per cycle while the output is ready; a two-result item makes
// the next wait for a pop. There is no path from out_o.ready to in_i.ready.
module json_token_lexer_core #(
  parameter int unsigned VALUE_WIDTH = jtl_pkg::ValueWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  jtl_in_if.sink              in_i,
  jtl_out_if.source           out_o
);

  localparam int unsigned AccW = VALUE_WIDTH + 4;

  typedef struct packed {
    jtl_pkg::kind_e         kind;
    logic [VALUE_WIDTH-1:0] value;
    logic                   negative;
    logic                   last;
  } res_t;

  // Lexer state.
  jtl_pkg::mode_e         mode_q, mode_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic                   real_q, real_d;
  logic                   neg_q, neg_d;
  logic                   dig_q, dig_d;
  logic                   ovf_q, ovf_d;
  logic                   stop_q, stop_d;
  logic [39:0]            wbuf_q, wbuf_d;
  logic [2:0]             wlen_q, wlen_d;
  logic [1:0]             hpc_q, hpc_d;

  // Result queue, head at entry 0.
  res_t       q_q [jtl_pkg::QueueDepth];
  res_t       q_d [jtl_pkg::QueueDepth];
  res_t       q_base [jtl_pkg::QueueDepth];
  logic [1:0] count_q, count_d;
  logic [1:0] cnt_pop;

  logic in_acc, pop, out_valid;

  logic [7:0]     c;
  logic           eot;
  logic           is_space, is_struct, is_line_end, is_digit, is_letter;
  jtl_pkg::kind_e s_kind;

  logic [1:0]   hpc_eff;
  logic         hex;
  logic         digit_ok;
  logic [3:0]   dval;
  logic [AccW-1:0] acc_ext, prod, sum, lim;

  res_t       num_res, word_res, s_res, r0, r1;
  logic [1:0] n_res;

  assign in_acc    = in_i.valid && in_i.ready;
  assign in_i.ready = (count_q < 2'd2);
  assign out_valid = (count_q != 2'd0);
  assign pop       = out_valid && out_o.ready;

  assign out_o.valid    = out_valid;
  assign out_o.kind     = q_q[0].kind;
  assign out_o.value    = q_q[0].value;
  assign out_o.negative = q_q[0].negative;
  assign out_o.last     = q_q[0].last;

  assign c   = in_i.char_in;
  assign eot = in_i.end_of_text;

  // Character classes.
  always_comb begin
    is_struct = 1'b1;
    s_kind    = jtl_pkg::KIND_OBJ_OPEN;
    case (c)
      "{": s_kind = jtl_pkg::KIND_OBJ_OPEN;
      "}": s_kind = jtl_pkg::KIND_OBJ_CLOSE;
      "[": s_kind = jtl_pkg::KIND_ARR_OPEN;
      "]": s_kind = jtl_pkg::KIND_ARR_CLOSE;
      ",": s_kind = jtl_pkg::KIND_COMMA;
      ":": s_kind = jtl_pkg::KIND_COLON;
      default: is_struct = 1'b0;
    endcase
  end

  assign is_line_end = (c == 8'h0a) || (c == 8'h0d) || (c == 8'h0b) || (c == 8'h0c);
  assign is_space    = is_line_end || (c == " ") || (c == 8'h09);
  assign is_digit    = (c >= "0") && (c <= "9");
  assign is_letter   = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));

  // Digit decode and overflow check for the number accumulator.
  always_comb begin
    hpc_eff = (hpc_q == jtl_pkg::HexZero) ? jtl_pkg::HexNoPfx : hpc_q;
    hex     = (hpc_eff == jtl_pkg::HexActive);
    digit_ok = 1'b1;
    dval     = 4'd0;
    if (is_digit) begin
      dval = 4'(c - "0");
    end else if (hex && (c >= "a") && (c <= "f")) begin
      dval = 4'(c - "a" + 8'd10);
    end else if (hex && (c >= "A") && (c <= "F")) begin
      dval = 4'(c - "A" + 8'd10);
    end else begin
      digit_ok = 1'b0;
    end
    acc_ext = {4'b0000, acc_q};
    prod    = hex ? (acc_ext << 4) : ((acc_ext << 3) + (acc_ext << 1));
    sum     = prod + {{(AccW-4){1'b0}}, dval};
    // Negative tokens may reach a magnitude of 2^(VALUE_WIDTH-1).
    lim     = neg_q ? ({{(AccW-1){1'b0}}, 1'b1} << (VALUE_WIDTH-1))
                    : {4'b0000, {VALUE_WIDTH{1'b1}}};
  end

  // Tokens that close a number or a word.
  always_comb begin
    num_res = '{kind: jtl_pkg::KIND_INVALID, value: '0, negative: 1'b0, last: 1'b0};
    if (real_q) begin
      num_res.kind = jtl_pkg::KIND_REAL;
    end else if (dig_q && !ovf_q) begin
      num_res.kind     = jtl_pkg::KIND_INTEGER;
      num_res.negative = neg_q;
      num_res.value    = neg_q ? (~acc_q + 1'b1) : acc_q;
    end

    word_res = '{kind: jtl_pkg::KIND_INVALID, value: '0, negative: 1'b0, last: 1'b0};
    if (wlen_q == 3'd4 && wbuf_q == jtl_pkg::WordNull) begin
      word_res.kind = jtl_pkg::KIND_NULL;
    end else if (wlen_q == 3'd4 && wbuf_q == jtl_pkg::WordTrue) begin
      word_res.kind  = jtl_pkg::KIND_BOOL;
      word_res.value = VALUE_WIDTH'(1);
    end else if (wlen_q == 3'd5 && wbuf_q == jtl_pkg::WordFalse) begin
      word_res.kind = jtl_pkg::KIND_BOOL;
    end

    s_res = '{kind: s_kind, value: '0, negative: 1'b0, last: 1'b0};
  end

  // Per-item lexer step.
  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    real_d = real_q;
    neg_d  = neg_q;
    dig_d  = dig_q;
    ovf_d  = ovf_q;
    stop_d = stop_q;
    wbuf_d = wbuf_q;
    wlen_d = wlen_q;
    hpc_d  = hpc_q;
    n_res  = 2'd0;
    r0 = '{kind: jtl_pkg::KIND_END, value: '0, negative: 1'b0, last: 1'b0};
    r1 = '{kind: jtl_pkg::KIND_END, value: '0, negative: 1'b0, last: 1'b0};

    if (in_acc && eot) begin
      unique case (mode_q)
        jtl_pkg::MODE_STR, jtl_pkg::MODE_ESC: begin
          r0.kind = jtl_pkg::KIND_UNTERM;
          n_res   = 2'd1;
        end
        jtl_pkg::MODE_NUM: begin
          r0    = num_res;
          n_res = 2'd2;
        end
        jtl_pkg::MODE_WORD: begin
          r0    = word_res;
          n_res = 2'd2;
        end
        jtl_pkg::MODE_SLASH, jtl_pkg::MODE_BADCMT: begin
          r0.kind = jtl_pkg::KIND_INVALID;
          n_res   = 2'd2;
        end
        default: n_res = 2'd1;
      endcase
      mode_d = jtl_pkg::MODE_IDLE;
      acc_d  = '0;
      real_d = 1'b0;
      neg_d  = 1'b0;
      dig_d  = 1'b0;
      ovf_d  = 1'b0;
      stop_d = 1'b0;
      wbuf_d = '0;
      wlen_d = 3'd0;
      hpc_d  = jtl_pkg::HexNone;
    end else if (in_acc) begin
      unique case (mode_q)
        jtl_pkg::MODE_STR: begin
          if (c == "\\") begin
            mode_d = jtl_pkg::MODE_ESC;
          end else if (c == "\"") begin
            r0.kind = jtl_pkg::KIND_STR_END;
            n_res   = 2'd1;
            mode_d  = jtl_pkg::MODE_IDLE;
          end else begin
            r0.kind  = jtl_pkg::KIND_STR_CHAR;
            r0.value = VALUE_WIDTH'(c);
            n_res    = 2'd1;
          end
        end
        jtl_pkg::MODE_ESC: begin
          r0.kind = jtl_pkg::KIND_STR_CHAR;
          case (c)
            "a":     r0.value = VALUE_WIDTH'(8'd7);
            "b":     r0.value = VALUE_WIDTH'(8'd8);
            "t":     r0.value = VALUE_WIDTH'(8'd9);
            "n":     r0.value = VALUE_WIDTH'(8'd10);
            "r":     r0.value = VALUE_WIDTH'(8'd13);
            "v":     r0.value = VALUE_WIDTH'(8'd11);
            "f":     r0.value = VALUE_WIDTH'(8'd12);
            "e":     r0.value = VALUE_WIDTH'(jtl_pkg::CharEscape);
            default: r0.value = VALUE_WIDTH'(c);
          endcase
          n_res  = 2'd1;
          mode_d = jtl_pkg::MODE_STR;
        end
        jtl_pkg::MODE_NUM: begin
          if (is_struct || is_space) begin
            r0     = num_res;
            r1     = s_res;
            n_res  = is_struct ? 2'd2 : 2'd1;
            mode_d = jtl_pkg::MODE_IDLE;
          end else begin
            if (c == "." || c == "e" || c == "E") begin
              real_d = 1'b1;
            end
            if (hpc_q == jtl_pkg::HexZero && (c == "x" || c == "X")) begin
              // The token opened with a 0x prefix; digits start after it.
              hpc_d = jtl_pkg::HexActive;
              acc_d = '0;
              dig_d = 1'b0;
            end else begin
              hpc_d = hpc_eff;
              if (!stop_q) begin
                if (digit_ok) begin
                  dig_d = 1'b1;
                  if (!ovf_q) begin
                    if (sum > lim) begin
                      ovf_d = 1'b1;
                    end else begin
                      acc_d = sum[VALUE_WIDTH-1:0];
                    end
                  end
                end else begin
                  stop_d = 1'b1;
                end
              end
            end
          end
        end
        jtl_pkg::MODE_WORD: begin
          if (is_struct || is_space) begin
            r0     = word_res;
            r1     = s_res;
            n_res  = is_struct ? 2'd2 : 2'd1;
            mode_d = jtl_pkg::MODE_IDLE;
          end else begin
            if (wlen_q < 3'd5) begin
              wbuf_d = {wbuf_q[31:0], c};
            end
            if (wlen_q < 3'd6) begin
              wlen_d = wlen_q + 3'd1;
            end
          end
        end
        jtl_pkg::MODE_CMT: begin
          if (is_line_end) begin
            mode_d = jtl_pkg::MODE_IDLE;
          end
        end
        jtl_pkg::MODE_SLASH: begin
          if (c == "/") begin
            mode_d = jtl_pkg::MODE_CMT;
          end else if (is_line_end) begin
            r0.kind = jtl_pkg::KIND_INVALID;
            n_res   = 2'd1;
            mode_d  = jtl_pkg::MODE_IDLE;
          end else begin
            mode_d = jtl_pkg::MODE_BADCMT;
          end
        end
        jtl_pkg::MODE_BADCMT: begin
          if (is_line_end) begin
            r0.kind = jtl_pkg::KIND_INVALID;
            n_res   = 2'd1;
            mode_d  = jtl_pkg::MODE_IDLE;
          end
        end
        default: begin
          mode_d = jtl_pkg::MODE_IDLE;
          if (is_struct) begin
            r0    = s_res;
            n_res = 2'd1;
          end else if (is_space) begin
            mode_d = jtl_pkg::MODE_IDLE;
          end else if (c == "#") begin
            mode_d = jtl_pkg::MODE_CMT;
          end else if (c == "/") begin
            mode_d = jtl_pkg::MODE_SLASH;
          end else if (c == "\"") begin
            mode_d = jtl_pkg::MODE_STR;
          end else if (c == "-") begin
            mode_d = jtl_pkg::MODE_NUM;
            acc_d  = '0;
            real_d = 1'b0;
            neg_d  = 1'b1;
            dig_d  = 1'b0;
            ovf_d  = 1'b0;
            stop_d = 1'b0;
            hpc_d  = jtl_pkg::HexNoPfx;
          end else if (is_digit) begin
            mode_d = jtl_pkg::MODE_NUM;
            acc_d  = VALUE_WIDTH'(dval);
            real_d = 1'b0;
            neg_d  = 1'b0;
            dig_d  = 1'b1;
            ovf_d  = 1'b0;
            stop_d = 1'b0;
            hpc_d  = (c == "0") ? jtl_pkg::HexZero : jtl_pkg::HexNoPfx;
          end else if (is_letter) begin
            mode_d = jtl_pkg::MODE_WORD;
            wbuf_d = {32'h0, c};
            wlen_d = 3'd1;
          end else begin
            r0.kind = jtl_pkg::KIND_INVALID;
            n_res   = 2'd1;
          end
        end
      endcase
    end

    r0.last = (n_res == 2'd1);
    r1.last = 1'b1;
  end

  // Result queue: pop shifts toward the head, new results land behind.
  always_comb begin
    cnt_pop   = count_q - {1'b0, pop};
    q_base[0] = pop ? q_q[1] : q_q[0];
    q_base[1] = pop ? q_q[2] : q_q[1];
    q_base[2] = q_q[2];
    for (int i = 0; i < jtl_pkg::QueueDepth; i++) begin
      q_d[i] = q_base[i];
      if (n_res != 2'd0 && cnt_pop == 2'(i)) begin
        q_d[i] = r0;
      end
      if (n_res == 2'd2 && (cnt_pop + 2'd1) == 2'(i)) begin
        q_d[i] = r1;
      end
    end
    count_d = cnt_pop + n_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= jtl_pkg::MODE_IDLE;
      acc_q   <= '0;
      real_q  <= 1'b0;
      neg_q   <= 1'b0;
      dig_q   <= 1'b0;
      ovf_q   <= 1'b0;
      stop_q  <= 1'b0;
      wbuf_q  <= '0;
      wlen_q  <= 3'd0;
      hpc_q   <= jtl_pkg::HexNone;
      count_q <= 2'd0;
    end else begin
      mode_q  <= mode_d;
      acc_q   <= acc_d;
      real_q  <= real_d;
      neg_q   <= neg_d;
      dig_q   <= dig_d;
      ovf_q   <= ovf_d;
      stop_q  <= stop_d;
      wbuf_q  <= wbuf_d;
      wlen_q  <= wlen_d;
      hpc_q   <= hpc_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < jtl_pkg::QueueDepth; i++) begin
      q_q[i] <= q_d[i];
    end
  end

  // An end-of-text item always produces a result and leaves the lexer idle.
  a_eot_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.end_of_text |=> mode_q == jtl_pkg::MODE_IDLE && count_q != 2'd0)
    else $error("end of text did not return the lexer to idle with a result");

  // A result not marked last always has its partner queued behind it.
  a_last_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !q_q[0].last |-> count_q >= 2'd2)
    else $error("result without last has no following result queued");

  // Inside a number the prefix state is always known.
  a_num_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == jtl_pkg::MODE_NUM |-> hpc_q != jtl_pkg::HexNone)
    else $error("number mode with no prefix state");

  // The word length never passes its saturation value.
  a_word_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == jtl_pkg::MODE_WORD |-> wlen_q != 3'd0 && wlen_q != 3'd7)
    else $error("word length out of range in word mode");

endmodule

// File: tb/sv/lexer_token_check.sv
module lexer_token_check #(
  parameter int unsigned VALUE_WIDTH = jtl_pkg::ValueWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  jtl_in_if           in_mon_i,
  jtl_out_if          out_mon_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClassSpace = 6;
  localparam int unsigned ClassOther = 7;
  localparam logic [VALUE_WIDTH-1:0] AllOnes = {VALUE_WIDTH{1'b1}};
  localparam logic [4:0] DecBase = 5'd10;
  localparam logic [4:0] HexBase = 5'd16;
  localparam logic [2:0] WordKeep = 3'd5;
  localparam logic [2:0] WordLong = 3'd6;

  localparam logic [7:0] ChBel = 8'h07;
  localparam logic [7:0] ChBs  = 8'h08;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChVt  = 8'h0B;
  localparam logic [7:0] ChFf  = 8'h0C;
  localparam logic [7:0] ChCr  = 8'h0D;

  typedef struct packed {
    jtl_pkg::kind_e         kind;
    logic [VALUE_WIDTH-1:0] value;
    logic                   negative;
    logic                   last;
  } token_t;

  token_t expected_tokens[$];
  token_t step_tokens[$];

  jtl_pkg::mode_e         mode;
  logic [VALUE_WIDTH-1:0] num_acc;
  logic                   num_real, num_neg, num_dig, num_ovf, num_stop;
  logic [1:0]             hex_state;
  logic [39:0]            word_buf;
  logic [2:0]             word_len;

  function automatic void emit(jtl_pkg::kind_e kind, logic [VALUE_WIDTH-1:0] value,
                               logic negative);
    token_t tok;
    tok.kind = kind;
    tok.value = value;
    tok.negative = negative;
    tok.last = 1'b0;
    step_tokens.insert(step_tokens.size(), tok);
  endfunction

  function automatic int unsigned char_class(logic [7:0] c);
    case (c)
      "{": return jtl_pkg::KIND_OBJ_OPEN;
      "}": return jtl_pkg::KIND_OBJ_CLOSE;
      "[": return jtl_pkg::KIND_ARR_OPEN;
      "]": return jtl_pkg::KIND_ARR_CLOSE;
      ",": return jtl_pkg::KIND_COMMA;
      ":": return jtl_pkg::KIND_COLON;
      " ", ChTab, ChLf, ChVt, ChFf, ChCr: return ClassSpace;
      default: return ClassOther;
    endcase
  endfunction

  function automatic logic is_line_end(logic [7:0] c);
    return c == ChLf || c == ChCr || c == ChVt || c == ChFf;
  endfunction

  function automatic logic [7:0] unescape(logic [7:0] c);
    case (c)
      "a": return ChBel;
      "b": return ChBs;
      "t": return ChTab;
      "n": return ChLf;
      "r": return ChCr;
      "v": return ChVt;
      "f": return ChFf;
      "e": return jtl_pkg::CharEscape;
      default: return c;
    endcase
  endfunction

  function automatic void clear_state();
    mode = jtl_pkg::MODE_IDLE;
    num_acc = '0;
    {num_real, num_neg, num_dig, num_ovf, num_stop} = '0;
    word_buf = '0;
    word_len = '0;
    hex_state = jtl_pkg::HexNone;
  endfunction

  // A negative token may reach a magnitude of 2^(VALUE_WIDTH-1).
  function automatic void accumulate(logic [4:0] digit, logic [4:0] base);
    logic [VALUE_WIDTH-1:0] limit;
    limit = num_neg ? (AllOnes >> 1) + 1'b1 : AllOnes;
    num_dig = 1'b1;
    if (!num_ovf) begin
      if (num_acc > (limit - VALUE_WIDTH'(digit)) / VALUE_WIDTH'(base)) begin
        num_ovf = 1'b1;
      end else begin
        num_acc = num_acc * VALUE_WIDTH'(base) + VALUE_WIDTH'(digit);
      end
    end
  endfunction

  function automatic void number_char(logic [7:0] c);
    logic [4:0] digit;
    logic       hex;
    digit = HexBase;
    if (c == "." || c == "e" || c == "E") num_real = 1'b1;
    if (hex_state == jtl_pkg::HexZero) begin
      if (c == "x" || c == "X") begin
        hex_state = jtl_pkg::HexActive;
        num_acc = '0;
        num_dig = 1'b0;
        return;
      end
      hex_state = jtl_pkg::HexNoPfx;
    end
    if (num_stop) return;
    hex = (hex_state == jtl_pkg::HexActive);
    if (c >= "0" && c <= "9") begin
      digit = 5'(c - "0");
    end else if (hex && c >= "a" && c <= "f") begin
      digit = 5'(c - "a" + 10);
    end else if (hex && c >= "A" && c <= "F") begin
      digit = 5'(c - "A" + 10);
    end
    if (digit < (hex ? HexBase : DecBase)) begin
      accumulate(digit, hex ? HexBase : DecBase);
    end else begin
      num_stop = 1'b1;
    end
  endfunction

  function automatic void close_number();
    if (num_real) begin
      emit(jtl_pkg::KIND_REAL, '0, 1'b0);
    end else if (!num_dig || num_ovf) begin
      emit(jtl_pkg::KIND_INVALID, '0, 1'b0);
    end else if (num_neg) begin
      emit(jtl_pkg::KIND_INTEGER, -num_acc, 1'b1);
    end else begin
      emit(jtl_pkg::KIND_INTEGER, num_acc, 1'b0);
    end
  endfunction

  function automatic void close_word();
    if (word_len == 3'd4 && word_buf == jtl_pkg::WordNull) begin
      emit(jtl_pkg::KIND_NULL, '0, 1'b0);
    end else if (word_len == 3'd4 && word_buf == jtl_pkg::WordTrue) begin
      emit(jtl_pkg::KIND_BOOL, VALUE_WIDTH'(1), 1'b0);
    end else if (word_len == 3'd5 && word_buf == jtl_pkg::WordFalse) begin
      emit(jtl_pkg::KIND_BOOL, '0, 1'b0);
    end else begin
      emit(jtl_pkg::KIND_INVALID, '0, 1'b0);
    end
  endfunction

  function automatic void start_token(logic [7:0] c);
    int unsigned cls;
    cls = char_class(c);
    if (cls < ClassSpace) begin
      emit(jtl_pkg::kind_e'(cls), '0, 1'b0);
    end else if (cls == ClassOther) begin
      if (c == "#") begin
        mode = jtl_pkg::MODE_CMT;
      end else if (c == "/") begin
        mode = jtl_pkg::MODE_SLASH;
      end else if (c == "\"") begin
        mode = jtl_pkg::MODE_STR;
      end else if (c == "-" || (c >= "0" && c <= "9")) begin
        mode = jtl_pkg::MODE_NUM;
        num_acc = '0;
        {num_real, num_neg, num_dig, num_ovf, num_stop} = '0;
        if (c == "-") begin
          num_neg = 1'b1;
          hex_state = jtl_pkg::HexNoPfx;
        end else begin
          hex_state = (c == "0") ? jtl_pkg::HexZero : jtl_pkg::HexNoPfx;
          accumulate(5'(c - "0"), DecBase);
        end
      end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
        mode = jtl_pkg::MODE_WORD;
        word_buf = 40'(c);
        word_len = 3'd1;
      end else begin
        emit(jtl_pkg::KIND_INVALID, '0, 1'b0);
      end
    end
  endfunction

  function automatic void predict_tokens(logic [7:0] c, logic eot);
    int unsigned cls;
    step_tokens.delete();
    if (eot) begin
      case (mode)
        jtl_pkg::MODE_STR, jtl_pkg::MODE_ESC: emit(jtl_pkg::KIND_UNTERM, '0, 1'b0);
        jtl_pkg::MODE_NUM: begin
          close_number();
          emit(jtl_pkg::KIND_END, '0, 1'b0);
        end
        jtl_pkg::MODE_WORD: begin
          close_word();
          emit(jtl_pkg::KIND_END, '0, 1'b0);
        end
        jtl_pkg::MODE_SLASH, jtl_pkg::MODE_BADCMT: begin
          emit(jtl_pkg::KIND_INVALID, '0, 1'b0);
          emit(jtl_pkg::KIND_END, '0, 1'b0);
        end
        default: emit(jtl_pkg::KIND_END, '0, 1'b0);
      endcase
      clear_state();
    end else begin
      cls = char_class(c);
      case (mode)
        jtl_pkg::MODE_STR: begin
          if (c == "\\") begin
            mode = jtl_pkg::MODE_ESC;
          end else if (c == "\"") begin
            emit(jtl_pkg::KIND_STR_END, '0, 1'b0);
            mode = jtl_pkg::MODE_IDLE;
          end else begin
            emit(jtl_pkg::KIND_STR_CHAR, VALUE_WIDTH'(c), 1'b0);
          end
        end
        jtl_pkg::MODE_ESC: begin
          emit(jtl_pkg::KIND_STR_CHAR, VALUE_WIDTH'(unescape(c)), 1'b0);
          mode = jtl_pkg::MODE_STR;
        end
        jtl_pkg::MODE_NUM: begin
          if (cls == ClassOther) begin
            number_char(c);
          end else begin
            close_number();
            mode = jtl_pkg::MODE_IDLE;
            if (cls < ClassSpace) emit(jtl_pkg::kind_e'(cls), '0, 1'b0);
          end
        end
        jtl_pkg::MODE_WORD: begin
          if (cls == ClassOther) begin
            if (word_len < WordKeep) word_buf = {word_buf[31:0], c};
            if (word_len < WordLong) word_len = word_len + 3'd1;
          end else begin
            close_word();
            mode = jtl_pkg::MODE_IDLE;
            if (cls < ClassSpace) emit(jtl_pkg::kind_e'(cls), '0, 1'b0);
          end
        end
        jtl_pkg::MODE_CMT: begin
          if (is_line_end(c)) mode = jtl_pkg::MODE_IDLE;
        end
        jtl_pkg::MODE_SLASH: begin
          if (c == "/") begin
            mode = jtl_pkg::MODE_CMT;
          end else if (is_line_end(c)) begin
            emit(jtl_pkg::KIND_INVALID, '0, 1'b0);
            mode = jtl_pkg::MODE_IDLE;
          end else begin
            mode = jtl_pkg::MODE_BADCMT;
          end
        end
        jtl_pkg::MODE_BADCMT: begin
          if (is_line_end(c)) begin
            emit(jtl_pkg::KIND_INVALID, '0, 1'b0);
            mode = jtl_pkg::MODE_IDLE;
          end
        end
        default: begin
          mode = jtl_pkg::MODE_IDLE;
          start_token(c);
        end
      endcase
    end
    if (step_tokens.size() > 0) begin
      step_tokens[step_tokens.size() - 1].last = 1'b1;
    end
    foreach (step_tokens[i]) expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
  endfunction

  function automatic void field_mismatch(string field, logic [63:0] want, logic [63:0] got);
    fail_count_o++;
    $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
  endfunction

  function automatic void compare_token();
    token_t want;
    if (expected_tokens.size() == 0) begin
      fail_count_o++;
      $error("token with no item pending: kind %0d value 0x%0h",
             out_mon_i.kind, out_mon_i.value);
      return;
    end
    want = expected_tokens.pop_front();
    if (out_mon_i.kind !== want.kind) field_mismatch("kind", 64'(want.kind), 64'(out_mon_i.kind));
    if (out_mon_i.value !== want.value) field_mismatch("value", 64'(want.value),
                                                       64'(out_mon_i.value));
    if (out_mon_i.negative !== want.negative) begin
      field_mismatch("negative", 64'(want.negative), 64'(out_mon_i.negative));
    end
    if (out_mon_i.last !== want.last) field_mismatch("last", 64'(want.last), 64'(out_mon_i.last));
  endfunction

  // Results of an item are registered in the result queue before they reach the
  // output, so the output is checked before the new item is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      expected_tokens.delete();
      fail_count_o = 0;
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) compare_token();
      if (in_mon_i.valid && in_mon_i.ready) predict_tokens(in_mon_i.char_in, in_mon_i.end_of_text);
    end
    pending_o = expected_tokens.size();
  end

endmodule

// File: tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ValueWidth = jtl_pkg::ValueWidthDefault;
  localparam int unsigned TextLength = 1150;
  localparam int unsigned SegmentItems = 150;
  localparam int unsigned QuietTail = 150;
  localparam int unsigned HoldAfterItems = 400;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned ResetCycles = 11;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned TimeoutNs = 2_000_000;

  localparam logic [7:0] SpaceChars[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
  localparam logic [7:0] LineEnds[4] = '{8'h0A, 8'h0D, 8'h0B, 8'h0C};

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } lex_item_t;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned stall_pct;
  int unsigned items_sent;
  logic        long_hold_done;
  lex_item_t   text_q[$];

  string struct_chars = "{}[],:";
  string esc_chars = "abtnrvfe\"\\/";
  string keywords[3] = '{"null", "true", "false"};
  string limit_values[4] = '{"18446744073709551615", "18446744073709551616",
                             "9223372036854775808", "9223372036854775809"};

  jtl_in_if in_ch ();
  jtl_out_if #(.VALUE_WIDTH(ValueWidth)) out_ch ();

  json_token_lexer_core #(.VALUE_WIDTH(ValueWidth)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  lexer_token_check #(.VALUE_WIDTH(ValueWidth)) u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic void add_entry(logic [7:0] c, logic eot);
    lex_item_t entry;
    entry.ch = c;
    entry.eot = eot;
    text_q.insert(text_q.size(), entry);
  endfunction

  function automatic void add_byte(logic [7:0] c);
    add_entry(c, 1'b0);
  endfunction

  function automatic void add_text(string s);
    foreach (s[i]) add_byte(s[i]);
  endfunction

  function automatic void add_end();
    add_entry(8'($urandom), 1'b1);
  endfunction

  function automatic logic [7:0] pick_letter();
    return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25)) : 8'("A" + $urandom_range(0, 25));
  endfunction

  // Numbers and words close on whitespace, on a structural character or at end of text.
  function automatic void add_terminator();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      add_byte(SpaceChars[$urandom_range(0, 5)]);
    end else if (r < 9) begin
      add_byte(struct_chars[$urandom_range(0, 5)]);
    end else begin
      add_end();
    end
  endfunction

  function automatic void gen_string();
    logic [7:0] c;
    add_byte("\"");
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 4) == 0) begin
        add_byte("\\");
        add_byte($urandom_range(0, 2) != 0 ? esc_chars[$urandom_range(0, 10)] : 8'($urandom));
      end else begin
        c = 8'($urandom);
        if (c == "\"" || c == "\\") c = "q";
        add_byte(c);
      end
    end
    if ($urandom_range(0, 11) == 0) begin
      add_end();
    end else begin
      add_byte("\"");
    end
  endfunction

  function automatic void gen_number();
    string       digits;
    logic [63:0] v;
    v = {$urandom, $urandom} >> $urandom_range(0, 63);
    if ($urandom_range(0, 2) == 0) add_byte("-");
    case ($urandom_range(0, 9))
      0, 1, 2: digits = $sformatf("%0d", v);
      3: digits = limit_values[$urandom_range(0, 3)];
      4, 5: begin
        if ($urandom_range(0, 5) == 0) begin
          digits = "";
        end else if ($urandom_range(0, 2) == 0) begin
          digits = $sformatf("%016h%0h", {$urandom, $urandom}, $urandom_range(0, 15));
        end else begin
          digits = $sformatf("%0h", v);
        end
        foreach (digits[i]) begin
          if (digits[i] >= "a" && digits[i] <= "f" && $urandom_range(0, 1)) begin
            digits[i] = digits[i] - 8'h20;
          end
        end
        digits = {($urandom_range(0, 1) ? "0x" : "0X"), digits};
      end
      6: digits = $sformatf("%0d%s%0d", v, ($urandom_range(0, 1) ? "." : "eE"),
                            $urandom_range(0, 99));
      7: begin
        digits = $sformatf("%0d", v);
        digits = {digits, ($urandom_range(0, 1) ? "x" : string'(8'($urandom)))};
        digits = {digits, $sformatf("%0d", $urandom_range(0, 999))};
      end
      8: digits = $urandom_range(0, 1) ? "0" : "";
      default: digits = $sformatf("%0d%0d", v, $urandom);
    endcase
    add_text(digits);
    add_terminator();
  endfunction

  function automatic void gen_word();
    string w;
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      w = keywords[$urandom_range(0, 2)];
    end else if (r < 8) begin
      w = keywords[$urandom_range(0, 2)];
      w = $urandom_range(0, 1) ? w.substr(0, w.len() - 2) : {w, string'(pick_letter())};
    end else begin
      w = string'(pick_letter());
      repeat ($urandom_range(0, 6)) begin
        w = {w, string'($urandom_range(0, 5) == 0 ? 8'($urandom) : pick_letter())};
      end
    end
    add_text(w);
    add_terminator();
  endfunction

  function automatic void gen_comment();
    logic [7:0] c;
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      add_byte("#");
    end else if (r < 7) begin
      add_text("//");
    end else begin
      add_byte("/");
      if ($urandom_range(0, 3) == 0) begin
        add_byte(LineEnds[$urandom_range(0, 3)]);
        return;
      end
      c = 8'($urandom);
      if (c == "/" || c == 8'h0A || c == 8'h0D || c == 8'h0B || c == 8'h0C) c = "z";
      add_byte(c);
    end
    repeat ($urandom_range(0, 6)) begin
      c = 8'($urandom);
      if (c == 8'h0A || c == 8'h0D || c == 8'h0B || c == 8'h0C) c = "k";
      add_byte(c);
    end
    if ($urandom_range(0, 7) == 0) begin
      add_end();
    end else begin
      add_byte(LineEnds[$urandom_range(0, 3)]);
    end
  endfunction

  function automatic void build_text();
    int unsigned r;
    // Short directed prologue: escape, negative zero, empty hex, real, stray
    // bytes at both ends of the range, an unterminated string and a bad comment.
    add_text("{\"\\e\":[-0,0x,1e]}");
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte("\"");
    add_end();
    add_text("/a");
    add_end();
    while (text_q.size() < TextLength) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        add_byte(struct_chars[$urandom_range(0, 5)]);
      end else if (r < 20) begin
        add_byte(SpaceChars[$urandom_range(0, 5)]);
      end else if (r < 42) begin
        gen_string();
      end else if (r < 68) begin
        gen_number();
      end else if (r < 81) begin
        gen_word();
      end else if (r < 89) begin
        gen_comment();
      end else if (r < 97) begin
        add_byte(8'($urandom));
      end else begin
        add_end();
      end
    end
  endfunction

  initial begin
    rst_ni <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.char_in <= '0;
    in_ch.end_of_text <= 1'b0;
    stall_pct = 0;
    items_sent = 0;
    build_text();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (text_q[i]) begin
      if (i % SegmentItems == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 40;
        endcase
      end
      if (i + QuietTail >= text_q.size()) stall_pct = 0;
      if ($urandom_range(1, 100) <= stall_pct) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
      in_ch.valid <= 1'b1;
      in_ch.char_in <= text_q[i].ch;
      in_ch.end_of_text <= text_q[i].eot;
      @(posedge clk_i);
      while (!in_ch.ready) @(posedge clk_i);
      items_sent++;
    end
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Token receiver. Once in the run it holds off long enough for the result
  // queue to fill, so the lexer has to stall its input.
  initial begin
    out_ch.ready <= 1'b0;
    long_hold_done = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!long_hold_done && items_sent >= HoldAfterItems) begin
        long_hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if ($urandom_range(1, 100) <= stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin
    #(TimeoutNs);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
